### sv/acof_pkg.sv
// Shared types, constants and helpers for the alternating-class arbiter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package acof_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;

    // Fixed field widths
    localparam int ID_W         = 24;
    localparam int SLOT_FIELD_W = 4;
    localparam int CNT_W        = 5;
    localparam int CFG_IDX_W    = 2;

    // Transaction command codes
    localparam logic CMD_ARRIVE  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EARLIEST_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_START     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVEN_TOTAL     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_TOTAL      = 2'd3;

    // Character codes bounding a decimal digit
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Filter broadcast to every cell during a scan
    typedef struct packed {
        logic only_earliest;
        logic class_matters;
        logic want;
    } filt_t;

    // Class of an id: odd digit in the last character gives 1, anything else 0
    function automatic logic class_of(input logic [ID_W-1:0] ident);
        logic [7:0] c;
        c = ident[7:0];
        if (c < CHAR_ZERO || c > CHAR_NINE)
        begin
            return 1'b0;
        end
        return c[0];
    endfunction

endpackage

### sv/acof_if.sv
// Handshake interfaces for the arbiter: request, response and register write.
// Depends on acof_pkg for widths and defaults.
interface acof_req_if #(
    parameter int TIME_BITS = acof_pkg::TIME_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [acof_pkg::SLOT_FIELD_W-1:0] slot;
    logic [acof_pkg::ID_W-1:0]     requester_id;
    logic [TIME_BITS-1:0]          start_time;
    logic [TIME_BITS-1:0]          now;

    modport source (output valid, cmd, slot, requester_id, start_time, now, input ready);
    modport sink   (input valid, cmd, slot, requester_id, start_time, now, output ready);
endinterface

interface acof_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [acof_pkg::SLOT_FIELD_W-1:0] grant_slot;
    logic [acof_pkg::ID_W-1:0]     grant_id;
    logic                          held;

    modport source (output valid, granted, grant_slot, grant_id, held, input ready);
    modport sink   (input valid, granted, grant_slot, grant_id, held, output ready);
endinterface

interface acof_cfg_if #(
    parameter int TIME_BITS = acof_pkg::TIME_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [acof_pkg::CFG_IDX_W-1:0] index;
    logic [TIME_BITS-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/alternating_class_oldest_first_arbiter_core.sv
// Top level of the alternating-class, oldest-first arbiter: control, registers
// and the row of slot cells. Depends on acof_pkg, acof_if.sv and acof_cell.
//
//  port | dir  | carries                                        | accepted when
//  -----+------+------------------------------------------------+------------------
//  req  | in   | cmd, slot, requester_id, start_time, now       | valid && ready
//  rsp  | out  | granted, grant_slot, grant_id, held            | valid && ready
//  cfg  | in   | index, data (register write)                   | valid && ready
//
// A transaction that finds the resource free after its own update passes
// through the idle state, which takes it and updates state, the prep state,
// which sets up the filter, the scan state, in which the best candidate ripples
// through the cell chain one cell per cycle, and the commit state, which commits
// the grant. A transaction that finds the resource still held skips the scan.
// The commit waits while an earlier response still sits in the output register.
// A new request is taken only in the idle state; cfg is always ready.
// Reset clears waiting flags and control state at once; no clearing pass.
module alternating_class_oldest_first_arbiter_core #(
    parameter int SLOTS     = acof_pkg::SLOTS_DEF,
    parameter int TIME_BITS = acof_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    acof_req_if.sink    req,
    acof_rsp_if.source  rsp,
    acof_cfg_if.sink    cfg
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TOK_W  = 1 + TIME_BITS + acof_pkg::ID_W + SLOT_W;

    typedef struct packed {
        logic                      found;
        logic [TIME_BITS-1:0]      start;
        logic [acof_pkg::ID_W-1:0] id;
        logic [SLOT_W-1:0]         idx;
    } tok_t;

    typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_SCAN, ST_COMMIT} state_t;

    // Configuration registers
    logic [TIME_BITS-1:0]       earliest_reg;
    logic [TIME_BITS-1:0]       last_reg;
    logic [acof_pkg::CNT_W-1:0] even_total_reg;
    logic [acof_pkg::CNT_W-1:0] odd_total_reg;

    // Control state
    state_t                     state_reg;
    state_t                     state_next;
    logic [SLOT_W-1:0]          cnt_reg;
    logic                       holding_reg;
    logic                       first_done_reg;
    logic                       holder_class_reg;
    logic                       previous_class_reg;
    logic [acof_pkg::CNT_W-1:0] fin_even_reg;
    logic [acof_pkg::CNT_W-1:0] fin_odd_reg;
    logic [TIME_BITS-1:0]       now_reg;
    logic                       scan_reg;
    acof_pkg::filt_t            filt_reg;

    // Output register
    logic                              out_valid_reg;
    logic                              out_granted_reg;
    logic [acof_pkg::SLOT_FIELD_W-1:0] out_slot_reg;
    logic [acof_pkg::ID_W-1:0]         out_id_reg;
    logic                              out_held_reg;

    logic                       req_fire;
    logic                       out_free;
    logic                       commit_go;
    logic                       commit_grant;
    logic                       need;
    logic                       relax;
    logic [SLOTS-1:0]           waiting_vec;
    logic [TOK_W-1:0]           tok_w [SLOTS+1];
    tok_t                       tok_last;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // Config writes must arrive only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            earliest_reg   <= '0;
            last_reg       <= '0;
            even_total_reg <= '0;
            odd_total_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                acof_pkg::REG_EARLIEST_START: earliest_reg   <= cfg.data;
                acof_pkg::REG_LAST_START:     last_reg       <= cfg.data;
                acof_pkg::REG_EVEN_TOTAL:     even_total_reg <= acof_pkg::CNT_W'(cfg.data);
                acof_pkg::REG_ODD_TOTAL:      odd_total_reg  <= acof_pkg::CNT_W'(cfg.data);
                default: ;
            endcase
        end
    end

    // Cell chain: the head sees an empty token, the tail holds the winner
    assign tok_w[0] = '0;
    assign tok_last = tok_t'(tok_w[SLOTS]);

    assign out_free     = !out_valid_reg || rsp.ready;
    assign commit_go    = (state_reg == ST_COMMIT) && out_free;
    assign commit_grant = commit_go && scan_reg && tok_last.found;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        logic wr_en;
        logic clr;

        // Arrive on an index beyond the row matches no cell and is dropped
        assign wr_en = req_fire && req.cmd == acof_pkg::CMD_ARRIVE
                    && 32'(req.slot) == 32'(g);
        assign clr   = commit_grant && 32'(tok_last.idx) == 32'(g);

        acof_cell #(
            .TIME_BITS (TIME_BITS),
            .SLOT_W    (SLOT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (SLOT_W'(g)),
            .wr_en    (wr_en),
            .wr_start (req.start_time),
            .wr_id    (req.requester_id),
            .clr      (clr),
            .filt     (filt_reg),
            .earliest (earliest_reg),
            .tok_in   (tok_w[g]),
            .tok_out  (tok_w[g+1]),
            .waiting  (waiting_vec[g])
        );
    end

    // Class rule: want the opposite of the last released holder; drop the rule
    // once now has reached the last start and that class has nobody left
    assign need  = ~previous_class_reg;
    assign relax = (now_reg >= last_reg)
                && (need ? (odd_total_reg <= fin_odd_reg) : (even_total_reg <= fin_even_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = holding_reg ? ST_COMMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            holding_reg        <= 1'b0;
            first_done_reg     <= 1'b0;
            holder_class_reg   <= 1'b0;
            previous_class_reg <= 1'b0;
            fin_even_reg       <= '0;
            fin_odd_reg        <= '0;
            scan_reg           <= 1'b0;
            filt_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the response once taken, unless a new one replaces it
            if (out_valid_reg && rsp.ready && !commit_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    // Release frees the resource; ignored while free
                    if (req_fire && req.cmd == acof_pkg::CMD_RELEASE && holding_reg)
                    begin
                        previous_class_reg <= holder_class_reg;
                        holding_reg        <= 1'b0;
                        if (!holder_class_reg)
                        begin
                            if (fin_even_reg < even_total_reg)
                            begin
                                fin_even_reg <= fin_even_reg + acof_pkg::CNT_W'(1);
                            end
                        end
                        else if (fin_odd_reg < odd_total_reg)
                        begin
                            fin_odd_reg <= fin_odd_reg + acof_pkg::CNT_W'(1);
                        end
                    end
                end
                ST_PREP:
                begin
                    cnt_reg                <= '0;
                    scan_reg               <= !holding_reg;
                    filt_reg.only_earliest <= !first_done_reg;
                    filt_reg.class_matters <= first_done_reg && !relax;
                    filt_reg.want          <= need;
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + SLOT_W'(1);
                end
                ST_COMMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (commit_grant)
                        begin
                            holding_reg      <= 1'b1;
                            first_done_reg   <= 1'b1;
                            holder_class_reg <= acof_pkg::class_of(tok_last.id);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: now for the class rule, response fields at commit
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            now_reg <= req.now;
        end
        if (commit_go)
        begin
            out_granted_reg <= commit_grant;
            out_slot_reg    <= commit_grant
                             ? acof_pkg::SLOT_FIELD_W'(32'(tok_last.idx)) : '0;
            out_id_reg      <= commit_grant ? tok_last.id : '0;
            out_held_reg    <= holding_reg || commit_grant;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.granted    = out_granted_reg;
    assign rsp.grant_slot = out_slot_reg;
    assign rsp.grant_id   = out_id_reg;
    assign rsp.held       = out_held_reg;

    // The chain winner must be a slot that is still waiting
    a_winner_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        commit_grant |-> waiting_vec[tok_last.idx])
        else $error("granted slot is not waiting");

    // A grant leaves the resource held
    a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
        commit_grant |=> holding_reg)
        else $error("grant did not take the resource");

    // A shown grant always reports the resource as held
    a_out_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_granted_reg) |-> out_held_reg)
        else $error("grant reported with resource free");

    // No scan while the resource is held
    a_no_scan_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !holding_reg)
        else $error("scan running while resource held");

endmodule

### sv/acof_cell.sv
// One requester slot: waiting flag, start time and id, plus one compare stage
// of the selection chain. Depends on acof_pkg.
module acof_cell #(
    parameter int TIME_BITS = acof_pkg::TIME_BITS_DEF,
    parameter int SLOT_W    = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [SLOT_W-1:0]          idx,
    input  logic                       wr_en,
    input  logic [TIME_BITS-1:0]       wr_start,
    input  logic [acof_pkg::ID_W-1:0]  wr_id,
    input  logic                       clr,
    input  acof_pkg::filt_t            filt,
    input  logic [TIME_BITS-1:0]       earliest,
    input  logic [1+TIME_BITS+acof_pkg::ID_W+SLOT_W-1:0] tok_in,
    output logic [1+TIME_BITS+acof_pkg::ID_W+SLOT_W-1:0] tok_out,
    output logic                       waiting
);

    typedef struct packed {
        logic                      found;
        logic [TIME_BITS-1:0]      start;
        logic [acof_pkg::ID_W-1:0] id;
        logic [SLOT_W-1:0]         idx;
    } tok_t;

    logic                      waiting_reg;
    logic [TIME_BITS-1:0]      start_reg;
    logic [acof_pkg::ID_W-1:0] id_reg;
    tok_t                      tok_reg;
    tok_t                      tok_prev;
    tok_t                      tok_next;
    logic                      eligible;
    logic                      better;

    assign tok_prev = tok_t'(tok_in);

    // Eligible under the broadcast filter
    assign eligible = waiting_reg
                   && (!filt.only_earliest || start_reg == earliest)
                   && (!filt.class_matters || acof_pkg::class_of(id_reg) == filt.want);

    // Strictly better only, so the lower slot keeps a full tie
    assign better = !tok_prev.found
                 || start_reg < tok_prev.start
                 || (start_reg == tok_prev.start && id_reg < tok_prev.id);

    always_comb
    begin
        if (eligible && better)
        begin
            tok_next = '{found: 1'b1, start: start_reg, id: id_reg, idx: idx};
        end
        else
        begin
            tok_next = tok_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            waiting_reg <= 1'b1;
        end
        else if (clr)
        begin
            waiting_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg <= wr_start;
            id_reg    <= wr_id;
        end
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;
    assign waiting = waiting_reg;

endmodule

### tb/arb_check_pkg.sv
`timescale 1ns / 100ps
// Transaction types and the grant scoreboard for the alternating-class arbiter bench.
// Depends on acof_pkg for field widths, command codes and register indexes.
package arb_check_pkg;

    localparam int NSLOT = acof_pkg::SLOTS_DEF;

    typedef struct packed {
        logic                              cmd;
        logic [acof_pkg::SLOT_FIELD_W-1:0] slot;
        logic [acof_pkg::ID_W-1:0]         requester_id;
        logic [15:0]                       start_time;
        logic [15:0]                       now;
    } arb_request_t;

    typedef struct packed {
        logic                              granted;
        logic [acof_pkg::SLOT_FIELD_W-1:0] grant_slot;
        logic [acof_pkg::ID_W-1:0]         grant_id;
        logic                              held;
    } arb_grant_t;

    class grant_tracker;
        bit [15:0] earliest_start;
        bit [15:0] last_start;
        bit [4:0]  even_total;
        bit [4:0]  odd_total;

        bit        slot_waiting [NSLOT];
        bit [15:0] slot_start   [NSLOT];
        bit [23:0] slot_ident   [NSLOT];
        bit        holding;
        bit        first_done;
        bit        holder_class;
        bit        previous_class;
        bit [4:0]  finished_even;
        bit [4:0]  finished_odd;

        arb_grant_t expected_grants [$];
        int         mismatches;

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        // Odd digit in the last character gives class 1, anything else class 0
        function bit id_class(bit [23:0] ident);
            bit [7:0] c;
            c = ident[7:0];
            if (c < acof_pkg::CHAR_ZERO || c > acof_pkg::CHAR_NINE)
            begin
                return 1'b0;
            end
            return c[0];
        endfunction

        function void write_register(logic [acof_pkg::CFG_IDX_W-1:0] index, logic [15:0] value);
            case (index)
                acof_pkg::REG_EARLIEST_START: earliest_start = value;
                acof_pkg::REG_LAST_START:     last_start     = value;
                acof_pkg::REG_EVEN_TOTAL:     even_total     = value[4:0];
                acof_pkg::REG_ODD_TOTAL:      odd_total      = value[4:0];
                default: ;
            endcase
        endfunction

        function int best_candidate(bit only_earliest, bit class_matters, bit want);
            int best;
            best = -1;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!slot_waiting[i])
                    continue;
                if (only_earliest && slot_start[i] != earliest_start)
                    continue;
                if (class_matters && id_class(slot_ident[i]) != want)
                    continue;
                if (best < 0 || slot_start[i] < slot_start[best] ||
                    (slot_start[i] == slot_start[best] && slot_ident[i] < slot_ident[best]))
                    best = i;
            end
            return best;
        endfunction

        function void note_request(arb_request_t item);
            int         pick;
            bit         need;
            bit [4:0]   total;
            bit [4:0]   done;
            bit         relax;
            arb_grant_t g;
            pick = -1;
            if (item.cmd == acof_pkg::CMD_ARRIVE)
            begin
                slot_waiting[item.slot] = 1'b1;
                slot_start[item.slot]   = item.start_time;
                slot_ident[item.slot]   = item.requester_id;
            end
            else if (holding)
            begin
                previous_class = holder_class;
                if (!holder_class)
                begin
                    if (finished_even < even_total)
                        finished_even++;
                end
                else if (finished_odd < odd_total)
                begin
                    finished_odd++;
                end
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (!first_done)
                begin
                    pick = best_candidate(1'b1, 1'b0, 1'b0);
                    if (pick >= 0)
                        first_done = 1'b1;
                end
                else
                begin
                    need  = ~previous_class;
                    total = need ? odd_total : even_total;
                    done  = need ? finished_odd : finished_even;
                    relax = (item.now >= last_start) && (total <= done);
                    pick  = best_candidate(1'b0, !relax, need);
                end
                if (pick >= 0)
                begin
                    slot_waiting[pick] = 1'b0;
                    holding            = 1'b1;
                    holder_class       = id_class(slot_ident[pick]);
                end
            end
            g = '0;
            if (pick >= 0)
            begin
                g.granted    = 1'b1;
                g.grant_slot = 4'(pick);
                g.grant_id   = slot_ident[pick];
            end
            g.held = holding;
            expected_grants.push_back(g);
        endfunction

        task check_grant(arb_grant_t got);
            arb_grant_t want;
            if (expected_grants.size() == 0)
            begin
                report($sformatf("unexpected response granted=%0b slot=%0d id=%06h held=%0b",
                                 got.granted, got.grant_slot, got.grant_id, got.held));
                return;
            end
            want = expected_grants.pop_front();
            if (got.granted !== want.granted)
                report($sformatf("granted %0b, predicted %0b", got.granted, want.granted));
            if (got.grant_slot !== want.grant_slot)
                report($sformatf("grant_slot %0d, predicted %0d", got.grant_slot, want.grant_slot));
            if (got.grant_id !== want.grant_id)
                report($sformatf("grant_id %06h, predicted %06h", got.grant_id, want.grant_id));
            if (got.held !== want.held)
                report($sformatf("held %0b, predicted %0b", got.held, want.held));
        endtask

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for alternating_class_oldest_first_arbiter_core: directed
// arrive/release transactions, then random requester sets. Depends on acof_pkg,
// the acof interfaces and arb_check_pkg.
module tb_top;

    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int REQ_W       = $bits(arb_check_pkg::arb_request_t);

    logic clk;
    logic rst_n;

    acof_req_if #(.TIME_BITS(16)) req_ch ();
    acof_rsp_if                   rsp_ch ();
    acof_cfg_if #(.TIME_BITS(16)) cfg_ch ();

    alternating_class_oldest_first_arbiter_core #(
        .SLOTS     (16),
        .TIME_BITS (16)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    arb_check_pkg::grant_tracker tracker = new;

    int items_sent;
    int sets_done;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_rsp;
    bit pressure_go;
    int cycle_count;

    // Free-running clock, 20 ns period
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: abandon the run if it overstays a generous cycle budget
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Response side: check each accepted transaction, then pick ready for the
    // next edge. Exactly one nonblocking write of ready per edge.
    initial
    begin
        arb_check_pkg::arb_grant_t got;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.granted    = rsp_ch.granted;
                got.grant_slot = rsp_ch.grant_slot;
                got.grant_id   = rsp_ch.grant_id;
                got.held       = rsp_ch.held;
                tracker.check_grant(got);
            end
            rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Back-pressure: once triggered, hold the response side off for a long
    // stretch so the output register fills and the request side stalls.
    initial
    begin
        hold_rsp <= 1'b0;
        do @(posedge clk); while (!pressure_go);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Drop valid for a random number of cycles; now and then a long gap so
    // that idle time lands on every stage of the scan.
    task automatic idle_gap();
        int n;
        if (send_idle_pct == 0)
            return;
        if ($urandom_range(15) == 0)
        begin
            n = $urandom_range(1, 25);
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        else if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Offer one request and hold it until the handshake completes
    task automatic send_item(arb_check_pkg::arb_request_t item);
        idle_gap();
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= item.cmd;
        req_ch.slot         <= item.slot;
        req_ch.requester_id <= item.requester_id;
        req_ch.start_time   <= item.start_time;
        req_ch.now          <= item.now;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        tracker.note_request(item);
        items_sent++;
        // Advance the idling pattern through its three stages
        if (items_sent == 200)
            pressure_go <= 1'b1;
        if (items_sent == ITEM_TARGET / 3)
        begin
            send_idle_pct <= 57;
            recv_idle_pct <= 9;
        end
        if (items_sent == 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    endtask

    task automatic arrive(int slot, logic [23:0] ident, int start, int now);
        arb_check_pkg::arb_request_t item;
        item.cmd          = acof_pkg::CMD_ARRIVE;
        item.slot         = 4'(slot);
        item.requester_id = ident;
        item.start_time   = 16'(start);
        item.now          = 16'(now);
        send_item(item);
    endtask

    // Slot, id and start are don't-care on release: randomise them anyway
    task automatic release_holder(int now);
        arb_check_pkg::arb_request_t item;
        item.cmd          = acof_pkg::CMD_RELEASE;
        item.slot         = 4'($urandom);
        item.requester_id = 24'($urandom);
        item.start_time   = 16'($urandom);
        item.now          = 16'(now);
        send_item(item);
    endtask

    // Stop offering and wait until every predicted response has been seen
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    // Write all four registers; only called with the block idle
    task automatic write_config(int es, int ls, int et, int ot);
        logic [acof_pkg::CFG_IDX_W-1:0] idx [4];
        int                             val [4];
        idx = '{acof_pkg::REG_EARLIEST_START, acof_pkg::REG_LAST_START,
                acof_pkg::REG_EVEN_TOTAL, acof_pkg::REG_ODD_TOTAL};
        val = '{es, ls, et, ot};
        for (int r = 0; r < 4; r++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[r];
            cfg_ch.data  <= 16'(val[r]);
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            tracker.write_register(idx[r], 16'(val[r]));
        end
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One requester set: build a well-formed population, configure to match
    // (mostly), then interleave arrivals and releases with some noise mixed in.
    task automatic run_set();
        int          n;
        int          es;
        int          ls;
        int          mode;
        int          now_t;
        int          arrived;
        int          released;
        int          j;
        int          tmp;
        int          n_even;
        int          n_odd;
        int          et;
        int          ot;
        int          slot_order [16];
        int          starts     [16];
        logic [23:0] ids        [16];
        logic [7:0]  last_char;
        arb_check_pkg::arb_request_t noise;

        mode = (sets_done < 2) ? sets_done : $urandom_range(2, 7);
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
        case (mode)
            0:       begin es = 0;     ls = 0;     end
            1:       begin es = 65535; ls = 65535; end
            2:       begin es = 0;     ls = 65535; end
            default: begin es = $urandom_range(0, 60000); ls = es + $urandom_range(0, 65535 - es); end
        endcase

        for (int k = 0; k < 16; k++)
            slot_order[k] = k;
        for (int k = 15; k > 0; k--)
        begin
            j = $urandom_range(k);
            tmp = slot_order[k];
            slot_order[k] = slot_order[j];
            slot_order[j] = tmp;
        end

        n_even = 0;
        n_odd  = 0;
        for (int k = 0; k < n; k++)
        begin
            starts[k] = $urandom_range(es, ls);
            if ($urandom_range(4) == 0)
                last_char = 8'($urandom);
            else
                last_char = 8'(acof_pkg::CHAR_ZERO + $urandom_range(9));
            ids[k] = {8'($urandom), 8'($urandom), last_char};
            if (tracker.id_class(ids[k]))
                n_odd++;
            else
                n_even++;
        end
        // Pin the extremes of the start window onto random members
        starts[$urandom_range(n - 1)] = es;
        starts[$urandom_range(n - 1)] = ls;

        if (mode == 0)
        begin
            et = 0;
            ot = 0;
        end
        else if (mode == 1)
        begin
            et = 16;
            ot = 16;
        end
        else if ($urandom_range(4) == 0)
        begin
            et = $urandom_range(16);
            ot = $urandom_range(16);
        end
        else
        begin
            et = n_even;
            ot = n_odd;
        end
        write_config(es, ls, et, ot);

        now_t    = $urandom_range(0, ls);
        arrived  = 0;
        released = 0;
        while (arrived < n || released < n + 2)
        begin
            if ($urandom_range(9) == 0)
            begin
                noise = arb_check_pkg::arb_request_t'(REQ_W'({$urandom, $urandom}));
                send_item(noise);
            end
            else if (arrived < n && (released >= n + 2 || $urandom_range(1) == 1))
            begin
                arrive(slot_order[arrived], ids[arrived], starts[arrived], now_t);
                arrived++;
            end
            else
            begin
                release_holder(now_t);
                released++;
            end
            // Let time run on; once everyone is in, often jump past the last start
            now_t = now_t + $urandom_range(0, 2000);
            if (arrived == n && $urandom_range(1) == 1)
                now_t = 65535;
            if (now_t > 65535)
                now_t = 65535;
        end
        drain();
        sets_done++;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= acof_pkg::CMD_ARRIVE;
        req_ch.slot         <= '0;
        req_ch.requester_id <= '0;
        req_ch.start_time   <= '0;
        req_ch.now          <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= acof_pkg::REG_EARLIEST_START;
        cfg_ch.data         <= '0;
        send_idle_pct       <= 9;
        recv_idle_pct       <= 57;
        pressure_go         <= 1'b0;
        items_sent          = 0;
        sets_done           = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first grant gated on the earliest start, ties, overwrites,
        // release while free, class relaxation and digit boundaries.
        write_config(100, 200, 2, 2);
        release_holder(0);                    // release while free
        arrive(3, "ab2", 150, 10);            // not the earliest start, no grant
        arrive(0, 24'hFFFFFF, 100, 10);       // earliest start, first grant
        arrive(15, "xy1", 120, 20);
        arrive(7, "xy1", 120, 20);            // full tie with slot 15
        release_holder(30);                   // lower slot wins the tie
        arrive(3, "zz4", 0, 40);              // overwrite a waiting slot
        release_holder(50);
        release_holder(60);
        release_holder(65535);                // nothing left of either class
        arrive(5, "aa9", 65535, 199);         // wrong class, before last start
        arrive(6, "aa3", 0, 200);             // class relaxed from last start on
        release_holder(0);                    // even needed, none left, too early
        release_holder(65535);                // free release, grant step relaxes
        arrive(9, 24'h000000, 0, 0);
        arrive(10, "qq/", 0, 0);
        arrive(11, "qq:", 1, 0);
        arrive(12, "qq0", 0, 0);
        arrive(13, "qq9", 0, 0);
        arrive(14, "qq8", 65535, 65535);
        release_holder(100);
        release_holder(65535);
        release_holder(0);
        release_holder(65535);
        drain();

        while (items_sent < ITEM_TARGET)
            run_set();

        // Let any late response show up before the verdict
        drain();
        repeat (60) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
